// File: rtl/fprc_pkg.sv
// Shared constants, codes and CRC function for the framed packet receiver.
package fprc_pkg;

    localparam int MAX_PAYLOAD = 128;
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0] SYNC_FIRST_RST = 8'h55;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam logic [2:0] PH_SYNC1 = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_SEQ = 3'd2;
    localparam logic [2:0] PH_LENLO = 3'd3;
    localparam logic [2:0] PH_LENHI = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;
    localparam logic [2:0] PH_CRCHI = 3'd6;
    localparam logic [2:0] PH_CRCLO = 3'd7;

    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_GOOD = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;
    localparam logic [1:0] ST_LONG = 2'd3;

    localparam logic REG_SYNC_FIRST = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] byte_out;
        logic [6:0] byte_index;
        logic [7:0] frame_seq;
        logic [15:0] frame_length;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/framed_packet_receiver_crc16.sv
// Byte-serial sync-framed packet receiver with CRC-16 payload check.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_ready    | byte_in
//  output   | out_valid / out_ready  | status, byte_out, byte_index, frame_seq,
//           |                        | frame_length
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (sync_first, sync_second)
//
// One byte per cycle while in_ready is high; a result appears in the cycle after
// its byte is taken. Parse state and CRC update with each taken byte; the result
// register holds one transaction; in_ready drops only while it is full and stalled.
// Reset loads the sync bytes 0x55/0xAA and returns to hunting for sync.
module framed_packet_receiver_crc16 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  byte_out,
    output logic [6:0]  byte_index,
    output logic [7:0]  frame_seq,
    output logic [15:0] frame_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] len_reg, len_next;
    logic [fprc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;

    logic                  out_valid_reg;
    fprc_pkg::result_t     res_reg;
    fprc_pkg::result_t     res_next;
    logic                  res_fire;
    logic                  in_fire;
    logic                  cfg_write;
    logic [15:0]           rx_crc;
    logic [fprc_pkg::CNT_W:0] cnt_inc;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata = {24'h000000,
        (paddr[2] == fprc_pkg::REG_SYNC_SECOND) ? sync_second_reg : sync_first_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg <= fprc_pkg::SYNC_FIRST_RST;
            sync_second_reg <= fprc_pkg::SYNC_SECOND_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == fprc_pkg::REG_SYNC_SECOND)
                sync_second_reg <= pwdata[7:0];
            else
                sync_first_reg <= pwdata[7:0];
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire = in_valid && in_ready;
    assign rx_crc = {crc_hi_reg, byte_in};
    assign cnt_inc = {1'b0, cnt_reg} + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        seq_next = seq_reg;
        len_lo_next = len_lo_reg;
        len_next = len_reg;
        cnt_next = cnt_reg;
        crc_next = crc_reg;
        crc_hi_next = crc_hi_reg;
        res_fire = 1'b0;
        res_next.status = fprc_pkg::ST_BYTE;
        res_next.byte_out = 8'h00;
        res_next.byte_index = 7'd0;
        res_next.frame_seq = seq_reg;
        res_next.frame_length = len_reg;
        unique case (phase_reg)
            fprc_pkg::PH_SYNC1:
            begin
                phase_next = (byte_in == sync_first_reg) ? fprc_pkg::PH_SYNC2
                                                         : fprc_pkg::PH_SYNC1;
            end
            fprc_pkg::PH_SYNC2:
            begin
                phase_next = (byte_in == sync_second_reg) ? fprc_pkg::PH_SEQ
                                                          : fprc_pkg::PH_SYNC1;
            end
            fprc_pkg::PH_SEQ:
            begin
                seq_next = byte_in;
                phase_next = fprc_pkg::PH_LENLO;
            end
            fprc_pkg::PH_LENLO:
            begin
                len_lo_next = byte_in;
                phase_next = fprc_pkg::PH_LENHI;
            end
            fprc_pkg::PH_LENHI:
            begin
                len_next = {byte_in, len_lo_reg};
                cnt_next = '0;
                crc_next = fprc_pkg::CRC_INIT;
                res_next.frame_length = {byte_in, len_lo_reg};
                if ({byte_in, len_lo_reg} > 16'(fprc_pkg::MAX_PAYLOAD))
                begin
                    res_fire = 1'b1;
                    res_next.status = fprc_pkg::ST_LONG;
                    phase_next = fprc_pkg::PH_SYNC1;
                end
                else if ({byte_in, len_lo_reg} == 16'h0000)
                    phase_next = fprc_pkg::PH_CRCHI;
                else
                    phase_next = fprc_pkg::PH_DATA;
            end
            fprc_pkg::PH_DATA:
            begin
                res_fire = 1'b1;
                res_next.status = fprc_pkg::ST_BYTE;
                res_next.byte_out = byte_in;
                res_next.byte_index = 7'(cnt_reg);
                crc_next = fprc_pkg::crc_byte(crc_reg, byte_in);
                cnt_next = cnt_inc[fprc_pkg::CNT_W-1:0];
                if (16'(cnt_inc) >= len_reg)
                    phase_next = fprc_pkg::PH_CRCHI;
            end
            fprc_pkg::PH_CRCHI:
            begin
                crc_hi_next = byte_in;
                phase_next = fprc_pkg::PH_CRCLO;
            end
            fprc_pkg::PH_CRCLO:
            begin
                res_fire = 1'b1;
                res_next.status = (rx_crc == crc_reg) ? fprc_pkg::ST_GOOD
                                                      : fprc_pkg::ST_BAD;
                phase_next = fprc_pkg::PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fprc_pkg::PH_SYNC1;
            seq_reg <= 8'h00;
            len_lo_reg <= 8'h00;
            len_reg <= 16'h0000;
            cnt_reg <= '0;
            crc_reg <= fprc_pkg::CRC_INIT;
            crc_hi_reg <= 8'h00;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            seq_reg <= seq_next;
            len_lo_reg <= len_lo_next;
            len_reg <= len_next;
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
            crc_hi_reg <= crc_hi_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && res_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_fire)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign status = res_reg.status;
    assign byte_out = res_reg.byte_out;
    assign byte_index = res_reg.byte_index;
    assign frame_seq = res_reg.frame_seq;
    assign frame_length = res_reg.frame_length;

endmodule

// File: rtl/fprc_checker.sv
// Port-level checker for the framed packet receiver, with its bind.
module fprc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  byte_out,
    input logic [6:0]  byte_index,
    input logic [15:0] frame_length,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(byte_out)
            && $stable(byte_index) && $stable(frame_length))
        else $error("result changed while stalled");

    a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != fprc_pkg::ST_BYTE |-> byte_out == 8'h00 && byte_index == 7'd0)
        else $error("closing result carries payload bits");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == fprc_pkg::ST_BYTE |->
            16'(byte_index) < frame_length
            && frame_length <= 16'(fprc_pkg::MAX_PAYLOAD))
        else $error("payload index outside announced length");

    a_long_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == fprc_pkg::ST_LONG |-> frame_length > 16'(fprc_pkg::MAX_PAYLOAD))
        else $error("drop reported for a legal length");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind framed_packet_receiver_crc16 fprc_checker u_fprc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .byte_out(byte_out),
    .byte_index(byte_index),
    .frame_length(frame_length),
    .pready(pready)
);
